>>> hw/rtl/dsd_pkg.sv
package dsd_pkg;

	localparam int REG_W = 13;
	localparam int FOCAL_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int COORD_W = 24;
	localparam int Z_W = 16;
	localparam int BIDX_W = 24;
	localparam int CNT_W = 25;

	// Q0.24 focal plus one bit for the half-pixel offset
	localparam int FRAC_SHIFT = 25;

	localparam int COORD_POS_MAX = 2 ** (COORD_W - 1) - 1;
	localparam int COORD_NEG_MAG = 2 ** (COORD_W - 1);
	localparam int Z_MAX = 2 ** Z_W - 1;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [REG_W-1:0] IMAGE_WIDTH_RST = REG_W'(640);
	localparam logic [REG_W-1:0] IMAGE_HEIGHT_RST = REG_W'(480);
	localparam logic [REG_W-1:0] GRID_WIDTH_RST = REG_W'(80);
	localparam logic [REG_W-1:0] GRID_HEIGHT_RST = REG_W'(60);
	localparam logic [FOCAL_W-1:0] INV_FOCAL_RST = FOCAL_W'(33554);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_GRID_WIDTH = 3'd2,
		CFG_GRID_HEIGHT = 3'd3,
		CFG_INV_FOCAL_X = 3'd4,
		CFG_INV_FOCAL_Y = 3'd5
	} cfg_index_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_MUL1,
		BK_MUL2,
		BK_RND,
		BK_OUT
	} back_state_t;

endpackage

>>> hw/rtl/dsd_fifo.sv
module dsd_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import dsd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;
	logic             push;
	logic             pop;

	assign push_ready = fill_q != (PTR_W + 1)'(QUEUE_DEPTH);
	assign pop_valid = fill_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (PTR_W + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> hw/rtl/dsd_div.sv
module dsd_div #(
	parameter int DVD_W = 26,
	parameter int DVS_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W:0]   rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DVS_W+1:0] trial;
	logic [DVS_W+1:0] diff;
	logic             fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits = trial >= {2'b00, dvs_q};
	assign diff = trial - {2'b00, dvs_q};
	assign done = !busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W:0] : trial[DVS_W:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

endmodule

>>> hw/rtl/dsd_front.sv
module dsd_front #(
	parameter int DIM_W = 13,
	parameter int ACC_W = 26,
	parameter int DEPTH_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    restart,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [DEPTH_BITS-1:0]   depth_value,
	input  logic [DIM_W-1:0]        img_w,
	input  logic [DIM_W-1:0]        img_h,
	input  logic [DIM_W-1:0]        grid_h,
	input  logic [DIM_W-1:0]        grid_w,
	output logic                    push_valid,
	input  logic                    push_ready,
	output logic [DEPTH_BITS-1:0]   push_depth,
	output logic [ACC_W-1:0]        push_col_acc,
	output logic [ACC_W-1:0]        push_row_acc,
	output logic [dsd_pkg::CNT_W-1:0] push_count,
	output logic                    push_last
);
	import dsd_pkg::*;

	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic [ACC_W-1:0] col_acc_q;
	logic [ACC_W-1:0] row_acc_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             last_row;
	logic             last_col;
	logic             accept;

	assign last_row = ({1'b0, row_q} + (DIM_W + 1)'(1)) >= {1'b0, grid_h};
	assign last_col = ({1'b0, col_q} + (DIM_W + 1)'(1)) >= {1'b0, grid_w};
	assign count_nxt = (depth_value != '0) ? count_q + CNT_W'(1) : count_q;

	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign accept = in_valid && push_ready;
	assign push_depth = depth_value;
	assign push_col_acc = col_acc_q;
	assign push_row_acc = row_acc_q;
	assign push_count = count_nxt;
	assign push_last = last_row && last_col;

	// column-major walk: row inner, column outer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			col_acc_q <= '0;
			row_acc_q <= '0;
			count_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			col_acc_q <= '0;
			row_acc_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
			if (last_row) begin
				row_q <= '0;
				row_acc_q <= '0;
				if (last_col) begin
					col_q <= '0;
					col_acc_q <= '0;
					count_q <= '0;
				end else begin
					col_q <= col_q + DIM_W'(1);
					col_acc_q <= col_acc_q + ACC_W'(img_w);
				end
			end else begin
				row_q <= row_q + DIM_W'(1);
				row_acc_q <= row_acc_q + ACC_W'(img_h);
			end
		end
	end

endmodule

>>> hw/rtl/dsd_back.sv
module dsd_back #(
	parameter int DIM_W = 13,
	parameter int ACC_W = 26,
	parameter int DEPTH_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  logic [DEPTH_BITS-1:0]           pop_depth,
	input  logic [ACC_W-1:0]                pop_col_acc,
	input  logic [ACC_W-1:0]                pop_row_acc,
	input  logic [dsd_pkg::CNT_W-1:0]       pop_count,
	input  logic                            pop_last,
	input  logic [DIM_W-1:0]                img_w,
	input  logic [DIM_W-1:0]                img_h,
	input  logic [DIM_W-1:0]                grid_w,
	input  logic [DIM_W-1:0]                grid_h,
	input  logic [dsd_pkg::FOCAL_W-1:0]     inv_fx,
	input  logic [dsd_pkg::FOCAL_W-1:0]     inv_fy,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            point_valid,
	output logic signed [dsd_pkg::COORD_W-1:0] point_x,
	output logic signed [dsd_pkg::COORD_W-1:0] point_y,
	output logic [dsd_pkg::Z_W-1:0]         point_z,
	output logic [dsd_pkg::BIDX_W-1:0]      buffer_index,
	output logic [dsd_pkg::CNT_W-1:0]       points_so_far,
	output logic                            frame_last
);
	import dsd_pkg::*;

	localparam int OFF_W = DIM_W + 1;
	localparam int DINV_W = DEPTH_BITS + FOCAL_W;
	localparam int MAG_W = DINV_W + OFF_W;
	localparam int QT_W = MAG_W + 1 - FRAC_SHIFT;
	localparam int QE_W = (QT_W > COORD_W + 1) ? QT_W : COORD_W + 1;
	localparam int ZE_W = (DEPTH_BITS > Z_W) ? DEPTH_BITS : Z_W;
	localparam int BM_W = 2 * DIM_W;
	localparam int BI_W = (BM_W + 1 > BIDX_W) ? BM_W + 1 : BIDX_W;
	localparam logic [MAG_W:0] ROUND_HALF = (MAG_W + 1)'(1) << (FRAC_SHIFT - 1);

	back_state_t state_q;
	back_state_t state_nxt;
	logic        div_start;
	logic        res_load;

	logic [ACC_W-1:0] quo_x;
	logic [ACC_W-1:0] quo_y;
	logic             done_x;
	logic             done_y;

	logic [DEPTH_BITS-1:0] depth_q;
	logic [CNT_W-1:0]      count_q;
	logic                  last_q;
	logic [DIM_W-1:0]      px_q;
	logic                  negx_q;
	logic                  negy_q;
	logic [OFF_W-1:0]      offx_q;
	logic [OFF_W-1:0]      offy_q;
	logic [DINV_W-1:0]     dinvx_q;
	logic [DINV_W-1:0]     dinvy_q;
	logic [BM_W-1:0]       bimul_q;
	logic [MAG_W-1:0]      magx_q;
	logic [MAG_W-1:0]      magy_q;
	logic [BIDX_W-1:0]     bidx_q;
	logic [QT_W-1:0]       qx_q;
	logic [QT_W-1:0]       qy_q;

	logic [DIM_W-1:0] px_c;
	logic [DIM_W-1:0] py_c;
	logic [OFF_W-1:0] ax;
	logic [OFF_W-1:0] ay;
	logic             negx;
	logic             negy;
	logic [OFF_W-1:0] offx;
	logic [OFF_W-1:0] offy;
	logic             has_pt;
	logic [ZE_W-1:0]  ze;
	logic [Z_W-1:0]   z_sat;

	logic                      out_valid_q;
	logic                      point_valid_q;
	logic signed [COORD_W-1:0] point_x_q;
	logic signed [COORD_W-1:0] point_y_q;
	logic [Z_W-1:0]            point_z_q;
	logic [BIDX_W-1:0]         buffer_index_q;
	logic [CNT_W-1:0]          points_so_far_q;
	logic                      frame_last_q;

	function automatic logic [COORD_W-1:0] saturate(input logic neg, input logic [QE_W-1:0] q);
		logic [COORD_W-1:0] r;
		if (neg) begin
			if (q > QE_W'(COORD_NEG_MAG)) begin
				r = {1'b1, {(COORD_W - 1){1'b0}}};
			end else begin
				r = -q[COORD_W-1:0];
			end
		end else begin
			if (q > QE_W'(COORD_POS_MAX)) begin
				r = {1'b0, {(COORD_W - 1){1'b1}}};
			end else begin
				r = q[COORD_W-1:0];
			end
		end
		return r;
	endfunction

	dsd_div #(
		.DVD_W(ACC_W),
		.DVS_W(DIM_W)
	) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(pop_col_acc),
		.divisor (grid_w),
		.done    (done_x),
		.quotient(quo_x)
	);

	dsd_div #(
		.DVD_W(ACC_W),
		.DVS_W(DIM_W)
	) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(pop_row_acc),
		.divisor (grid_h),
		.done    (done_y),
		.quotient(quo_y)
	);

	// pixel clamp and signed half-pixel offset
	assign px_c = (quo_x >= ACC_W'(img_w)) ? img_w - DIM_W'(1) : quo_x[DIM_W-1:0];
	assign py_c = (quo_y >= ACC_W'(img_h)) ? img_h - DIM_W'(1) : quo_y[DIM_W-1:0];
	assign ax = {px_c, 1'b0};
	assign ay = {py_c, 1'b0};
	assign negx = ax < {1'b0, img_w};
	assign negy = ay < {1'b0, img_h};
	assign offx = negx ? {1'b0, img_w} - ax : ax - {1'b0, img_w};
	assign offy = negy ? {1'b0, img_h} - ay : ay - {1'b0, img_h};

	assign has_pt = depth_q != '0;
	assign ze = ZE_W'(depth_q);
	assign z_sat = (ze > ZE_W'(Z_MAX)) ? Z_W'(Z_MAX) : ze[Z_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		pop_ready = 1'b0;
		div_start = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					div_start = 1'b1;
					state_nxt = BK_DIV;
				end
			end
			BK_DIV: begin
				if (done_x && done_y) begin
					state_nxt = BK_MUL1;
				end
			end
			BK_MUL1: state_nxt = BK_MUL2;
			BK_MUL2: state_nxt = BK_RND;
			BK_RND: state_nxt = BK_OUT;
			BK_OUT: begin
				// result register frees up as the pending beat leaves
				if (!out_valid_q || out_ready) begin
					res_load = 1'b1;
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && pop_valid) begin
			depth_q <= pop_depth;
			count_q <= pop_count;
			last_q <= pop_last;
		end
		if (state_q == BK_MUL1) begin
			px_q <= px_c;
			negx_q <= negx;
			negy_q <= negy;
			offx_q <= offx;
			offy_q <= offy;
			dinvx_q <= DINV_W'(depth_q) * DINV_W'(inv_fx);
			dinvy_q <= DINV_W'(depth_q) * DINV_W'(inv_fy);
			bimul_q <= BM_W'(py_c) * BM_W'(img_w);
		end
		if (state_q == BK_MUL2) begin
			magx_q <= MAG_W'(dinvx_q) * MAG_W'(offx_q);
			magy_q <= MAG_W'(dinvy_q) * MAG_W'(offy_q);
			bidx_q <= BIDX_W'(BI_W'(bimul_q) + BI_W'(px_q));
		end
		if (state_q == BK_RND) begin
			// round half away from zero on the magnitude
			qx_q <= QT_W'(((MAG_W + 1)'(magx_q) + ROUND_HALF) >> FRAC_SHIFT);
			qy_q <= QT_W'(((MAG_W + 1)'(magy_q) + ROUND_HALF) >> FRAC_SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			point_valid_q <= has_pt;
			point_x_q <= has_pt ? saturate(negx_q, QE_W'(qx_q)) : '0;
			point_y_q <= has_pt ? saturate(negy_q, QE_W'(qy_q)) : '0;
			point_z_q <= has_pt ? z_sat : '0;
			buffer_index_q <= bidx_q;
			points_so_far_q <= count_q;
			frame_last_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign point_valid = point_valid_q;
	assign point_x = point_x_q;
	assign point_y = point_y_q;
	assign point_z = point_z_q;
	assign buffer_index = buffer_index_q;
	assign points_so_far = points_so_far_q;
	assign frame_last = frame_last_q;

endmodule

>>> hw/rtl/depth_subsample_deproject_unit.sv
// channel   handshake              payload
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
// in        in_valid/in_ready      depth_value
// out       out_valid/out_ready    point_valid, point_x, point_y, point_z,
//                                  buffer_index, points_so_far, frame_last
//
// in the back end each sample runs through the two bit-serial pixel dividers, one
// quotient bit per cycle, then the MUL1, MUL2, RND and OUT states, one sample at a time.
// the front walks the grid at one beat per cycle, while the two-entry queue has room,
// so up to four samples sit inside while the back end works and a result waits.
// reset restores the default geometry and focal registers and starts a new frame.
// out_ready low holds the result register; the back end and queue keep going until full.
module depth_subsample_deproject_unit #(
	parameter int MAX_DIM = 4096,
	parameter int DEPTH_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [DEPTH_BITS-1:0]             depth_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              point_valid,
	output logic signed [dsd_pkg::COORD_W-1:0] point_x,
	output logic signed [dsd_pkg::COORD_W-1:0] point_y,
	output logic [dsd_pkg::Z_W-1:0]           point_z,
	output logic [dsd_pkg::BIDX_W-1:0]        buffer_index,
	output logic [dsd_pkg::CNT_W-1:0]         points_so_far,
	output logic                              frame_last
);
	import dsd_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int ACC_W = 2 * DIM_W;
	localparam int ENTRY_W = DEPTH_BITS + 2 * ACC_W + CNT_W + 1;

	logic [REG_W-1:0]   img_w_q;
	logic [REG_W-1:0]   img_h_q;
	logic [REG_W-1:0]   grid_w_q;
	logic [REG_W-1:0]   grid_h_q;
	logic [FOCAL_W-1:0] inv_fx_q;
	logic [FOCAL_W-1:0] inv_fy_q;

	logic             cfg_wr;
	logic             geom_restart;
	logic [DIM_W-1:0] img_w;
	logic [DIM_W-1:0] img_h;
	logic [DIM_W-1:0] grid_w;
	logic [DIM_W-1:0] grid_h;

	logic                  push_valid;
	logic                  push_ready;
	logic [DEPTH_BITS-1:0] push_depth;
	logic [ACC_W-1:0]      push_col_acc;
	logic [ACC_W-1:0]      push_row_acc;
	logic [CNT_W-1:0]      push_count;
	logic                  push_last;
	logic [ENTRY_W-1:0]    push_data;

	logic                  pop_valid;
	logic                  pop_ready;
	logic [ENTRY_W-1:0]    pop_data;
	logic [DEPTH_BITS-1:0] pop_depth;
	logic [ACC_W-1:0]      pop_col_acc;
	logic [ACC_W-1:0]      pop_row_acc;
	logic [CNT_W-1:0]      pop_count;
	logic                  pop_last;

	// zero reads as one, anything above MAX_DIM as MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [REG_W-1:0] v);
		int vi;
		vi = int'(v);
		if (vi == 0) begin
			vi = 1;
		end else if (vi > MAX_DIM) begin
			vi = MAX_DIM;
		end
		return DIM_W'(vi);
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign geom_restart = cfg_wr && (cfg_index == CFG_IMAGE_WIDTH ||
		cfg_index == CFG_IMAGE_HEIGHT || cfg_index == CFG_GRID_WIDTH ||
		cfg_index == CFG_GRID_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= IMAGE_WIDTH_RST;
			img_h_q <= IMAGE_HEIGHT_RST;
			grid_w_q <= GRID_WIDTH_RST;
			grid_h_q <= GRID_HEIGHT_RST;
			inv_fx_q <= INV_FOCAL_RST;
			inv_fy_q <= INV_FOCAL_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH: img_w_q <= cfg_data[REG_W-1:0];
				CFG_IMAGE_HEIGHT: img_h_q <= cfg_data[REG_W-1:0];
				CFG_GRID_WIDTH: grid_w_q <= cfg_data[REG_W-1:0];
				CFG_GRID_HEIGHT: grid_h_q <= cfg_data[REG_W-1:0];
				CFG_INV_FOCAL_X: inv_fx_q <= cfg_data[FOCAL_W-1:0];
				CFG_INV_FOCAL_Y: inv_fy_q <= cfg_data[FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign img_w = eff_dim(img_w_q);
	assign img_h = eff_dim(img_h_q);
	assign grid_w = eff_dim(grid_w_q);
	assign grid_h = eff_dim(grid_h_q);

	dsd_front #(
		.DIM_W     (DIM_W),
		.ACC_W     (ACC_W),
		.DEPTH_BITS(DEPTH_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (geom_restart),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.depth_value (depth_value),
		.img_w       (img_w),
		.img_h       (img_h),
		.grid_h      (grid_h),
		.grid_w      (grid_w),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_depth  (push_depth),
		.push_col_acc(push_col_acc),
		.push_row_acc(push_row_acc),
		.push_count  (push_count),
		.push_last   (push_last)
	);

	assign push_data = {push_depth, push_col_acc, push_row_acc, push_count, push_last};

	dsd_fifo #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	assign {pop_depth, pop_col_acc, pop_row_acc, pop_count, pop_last} = pop_data;

	dsd_back #(
		.DIM_W     (DIM_W),
		.ACC_W     (ACC_W),
		.DEPTH_BITS(DEPTH_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_depth    (pop_depth),
		.pop_col_acc  (pop_col_acc),
		.pop_row_acc  (pop_row_acc),
		.pop_count    (pop_count),
		.pop_last     (pop_last),
		.img_w        (img_w),
		.img_h        (img_h),
		.grid_w       (grid_w),
		.grid_h       (grid_h),
		.inv_fx       (inv_fx_q),
		.inv_fy       (inv_fy_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_valid  (point_valid),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.buffer_index (buffer_index),
		.points_so_far(points_so_far),
		.frame_last   (frame_last)
	);

	a_empty_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> point_x == '0 && point_y == '0 && point_z == '0)
		else $error("beat without a point carries nonzero coordinates");

	a_frame_wrap_count: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_ready && push_last |=>
		push_count == '0 || push_count == CNT_W'(1))
		else $error("point count not cleared after the last grid sample");

	a_restart_count: assert property (@(posedge clk) disable iff (!arst_n)
		geom_restart |=> push_count == '0 || push_count == CNT_W'(1))
		else $error("point count not cleared after a geometry write");

endmodule

>>> test/tb.sv
module tb;
	import dsd_pkg::*;

	localparam int MAX_DIM = 4096;
	localparam int DEPTH_BITS = 16;
	localparam int ITEM_TARGET = 850;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT = 4000;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

	typedef struct {
		logic                      point_valid;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [Z_W-1:0]            point_z;
		logic [BIDX_W-1:0]         buffer_index;
		logic [CNT_W-1:0]          points_so_far;
		logic                      frame_last;
	} point_t;

	class point_board;
		point_t expected_points[$];
		int unsigned fails;
		logic [REG_W-1:0] width_reg, height_reg, grid_w_reg, grid_h_reg;
		logic [FOCAL_W-1:0] inv_fx, inv_fy;
		logic [11:0] col, row;
		logic [23:0] col_acc, row_acc;
		logic [CNT_W-1:0] n_points;

		function new();
			fails = 0;
			width_reg = IMAGE_WIDTH_RST;
			height_reg = IMAGE_HEIGHT_RST;
			grid_w_reg = GRID_WIDTH_RST;
			grid_h_reg = GRID_HEIGHT_RST;
			inv_fx = INV_FOCAL_RST;
			inv_fy = INV_FOCAL_RST;
			restart();
		endfunction

		function void restart();
			col = '0;
			row = '0;
			col_acc = '0;
			row_acc = '0;
			n_points = '0;
		endfunction

		function int unsigned clip_dim(logic [REG_W-1:0] v);
			if (v == 0) return 1;
			if (v > MAX_DIM) return MAX_DIM;
			return v;
		endfunction

		// offset in half pixels times depth times Q0.24 focal, rounded half away from zero
		function logic signed [COORD_W-1:0] camera_coord(int unsigned pix, int unsigned dim,
				int unsigned d, logic [FOCAL_W-1:0] inv);
			longint unsigned off, mag, q;
			logic [63:0] r;
			bit neg;
			neg = 2 * pix < dim;
			off = neg ? dim - 2 * pix : 2 * pix - dim;
			mag = off * d * inv;
			q = (mag + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
			if (neg) begin
				if (q > COORD_NEG_MAG) q = COORD_NEG_MAG;
				r = 64'd0 - q;
			end else begin
				if (q > COORD_POS_MAX) q = COORD_POS_MAX;
				r = q;
			end
			return r[COORD_W-1:0];
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_IMAGE_WIDTH: begin
					width_reg = data[REG_W-1:0];
					restart();
				end
				CFG_IMAGE_HEIGHT: begin
					height_reg = data[REG_W-1:0];
					restart();
				end
				CFG_GRID_WIDTH: begin
					grid_w_reg = data[REG_W-1:0];
					restart();
				end
				CFG_GRID_HEIGHT: begin
					grid_h_reg = data[REG_W-1:0];
					restart();
				end
				CFG_INV_FOCAL_X: inv_fx = data[FOCAL_W-1:0];
				CFG_INV_FOCAL_Y: inv_fy = data[FOCAL_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [DEPTH_BITS-1:0] depth_in);
			int unsigned w, h, sw, sh, d, px, py;
			bit last_row, last_col, pv;
			point_t p;
			w = clip_dim(width_reg);
			h = clip_dim(height_reg);
			sw = clip_dim(grid_w_reg);
			sh = clip_dim(grid_h_reg);
			d = depth_in;
			px = col_acc / sw;
			py = row_acc / sh;
			last_row = int'(row) + 1 >= sh;
			last_col = int'(col) + 1 >= sw;
			pv = d != 0;
			if (px >= w) px = w - 1;
			if (py >= h) py = h - 1;
			if (pv) n_points = n_points + 1'b1;
			p.point_valid = pv;
			p.point_x = pv ? camera_coord(px, w, d, inv_fx) : '0;
			p.point_y = pv ? camera_coord(py, h, d, inv_fy) : '0;
			p.point_z = pv ? Z_W'((d > Z_MAX) ? Z_MAX : d) : '0;
			p.buffer_index = BIDX_W'(py * w + px);
			p.points_so_far = n_points;
			p.frame_last = last_row && last_col;
			expected_points.push_back(p);
			if (last_row) begin
				row = '0;
				row_acc = '0;
				if (last_col) begin
					restart();
				end else begin
					col = col + 1'b1;
					col_acc = 24'(col_acc + w);
				end
			end else begin
				row = row + 1'b1;
				row_acc = 24'(row_acc + h);
			end
		endfunction

		function void check_point(point_t got);
			point_t want;
			if (expected_points.size() == 0) begin
				$error("point beat with no sample outstanding");
				fails++;
				return;
			end
			want = expected_points.pop_front();
			if (got.point_valid !== want.point_valid) begin
				$error("point_valid expected %0d actual %0d", want.point_valid, got.point_valid);
				fails++;
			end
			if (got.point_x !== want.point_x) begin
				$error("point_x expected %0d actual %0d", want.point_x, got.point_x);
				fails++;
			end
			if (got.point_y !== want.point_y) begin
				$error("point_y expected %0d actual %0d", want.point_y, got.point_y);
				fails++;
			end
			if (got.point_z !== want.point_z) begin
				$error("point_z expected %0d actual %0d", want.point_z, got.point_z);
				fails++;
			end
			if (got.buffer_index !== want.buffer_index) begin
				$error("buffer_index expected %0d actual %0d", want.buffer_index,
					got.buffer_index);
				fails++;
			end
			if (got.points_so_far !== want.points_so_far) begin
				$error("points_so_far expected %0d actual %0d", want.points_so_far,
					got.points_so_far);
				fails++;
			end
			if (got.frame_last !== want.frame_last) begin
				$error("frame_last expected %0d actual %0d", want.frame_last, got.frame_last);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [DEPTH_BITS-1:0] depth_value;
	logic out_valid;
	logic out_ready;
	logic point_valid;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [Z_W-1:0] point_z;
	logic [BIDX_W-1:0] buffer_index;
	logic [CNT_W-1:0] points_so_far;
	logic frame_last;

	point_board board;
	bit idle_on;
	bit hold_req;
	int unsigned stall_cycles = 0;

	depth_subsample_deproject_unit #(
		.MAX_DIM(MAX_DIM),
		.DEPTH_BITS(DEPTH_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.depth_value(depth_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.point_valid(point_valid),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.buffer_index(buffer_index),
		.points_so_far(points_so_far),
		.frame_last(frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	// point receiver: random stalls plus one long hold-off on request
	initial begin
		point_t got;
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.point_valid = point_valid;
				got.point_x = point_x;
				got.point_y = point_y;
				got.point_z = point_z;
				got.buffer_index = buffer_index;
				got.points_so_far = points_so_far;
				got.frame_last = frame_last;
				board.check_point(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(idle_on && $urandom_range(99) < 38);
			end
		end
	end

	// leaves valid high on return so back-to-back beats never drop it
	task automatic send_sample(input logic [DEPTH_BITS-1:0] d);
		while (idle_on && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		depth_value <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_sample(d);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		while (board.expected_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [DEPTH_BITS-1:0] pick_depth();
		int r;
		r = $urandom_range(99);
		if (r < 15) return '0;
		if (r < 20) return '1;
		if (r < 25) return DEPTH_BITS'(1);
		return DEPTH_BITS'($urandom);
	endfunction

	// upper bits are ignored by the block, keep them toggling
	function automatic logic [CFG_DATA_W-1:0] dim_word(int unsigned v);
		return {11'($urandom), 13'(v)};
	endfunction

	function automatic int unsigned pick_image_dim();
		case ($urandom_range(9))
			0: return 0;
			1: return 1;
			2: return MAX_DIM;
			3: return $urandom_range(8191, MAX_DIM + 1);
			default: return $urandom_range(MAX_DIM, 1);
		endcase
	endfunction

	// mostly tiny grids so frames wrap often
	function automatic int unsigned pick_grid_dim();
		case ($urandom_range(11))
			0: return 0;
			1: return MAX_DIM;
			2: return 8191;
			default: return $urandom_range(6, 1);
		endcase
	endfunction

	function automatic logic [FOCAL_W-1:0] pick_focal();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return FOCAL_W'($urandom_range(40000, 20000));
			default: return FOCAL_W'($urandom);
		endcase
	endfunction

	task automatic pick_setup();
		int kind;
		kind = $urandom_range(9);
		if (kind < 6) begin
			cfg_write(CFG_IMAGE_WIDTH, dim_word(pick_image_dim()));
			cfg_write(CFG_IMAGE_HEIGHT, dim_word(pick_image_dim()));
			cfg_write(CFG_GRID_WIDTH, dim_word(pick_grid_dim()));
			cfg_write(CFG_GRID_HEIGHT, dim_word(pick_grid_dim()));
		end
		if (kind == 9) begin
			cfg_write(CFG_SPARE_6, CFG_DATA_W'($urandom));
			cfg_write(CFG_SPARE_7, CFG_DATA_W'($urandom));
		end
		cfg_write(CFG_INV_FOCAL_X, pick_focal());
		cfg_write(CFG_INV_FOCAL_Y, pick_focal());
	endtask

	initial begin
		int sent, n, phase;
		board = new();
		idle_on = 1'b1;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		depth_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: no depth, extreme and patterned depths
		send_sample(16'h0000);
		send_sample(16'h0001);
		send_sample(16'hFFFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		in_valid <= 1'b0;
		settle();

		// focal change mid-frame keeps the grid position
		cfg_write(CFG_INV_FOCAL_X, 24'hFFFFFF);
		cfg_write(CFG_INV_FOCAL_Y, 24'h000000);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'h0001);
		in_valid <= 1'b0;
		settle();

		// out-of-range dims clip, 3x1 grid saturates both ways and wraps
		cfg_write(CFG_IMAGE_WIDTH, 24'hFFF000);
		cfg_write(CFG_IMAGE_HEIGHT, 24'h001FFF);
		cfg_write(CFG_GRID_WIDTH, 24'd3);
		cfg_write(CFG_GRID_HEIGHT, 24'd0);
		cfg_write(CFG_INV_FOCAL_Y, 24'hFFFFFF);
		send_sample(16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		in_valid <= 1'b0;
		settle();

		// writes to unmapped indexes change nothing
		cfg_write(CFG_SPARE_6, 24'hABCDEF);
		cfg_write(CFG_SPARE_7, 24'h543210);
		send_sample(16'h1234);
		send_sample(16'h0000);
		in_valid <= 1'b0;
		sent = 16;

		phase = 0;
		while (sent < ITEM_TARGET) begin
			settle();
			pick_setup();
			if (phase == 3) begin
				// free-running stretch that starts with the receiver backed up
				idle_on = 1'b0;
				hold_req = 1'b1;
				n = 150;
			end else begin
				idle_on = 1'b1;
				n = $urandom_range(60, 15);
			end
			repeat (n) send_sample(pick_depth());
			in_valid <= 1'b0;
			sent += n;
			phase++;
		end
		idle_on = 1'b1;
		settle();

		if (board.fails == 0 && board.expected_points.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
